### sv/lzse_pkg.sv
// Shared constants and control types of the LZSS stream expander.
package lzse_pkg;

	// Window geometry follows the 12-bit match distance of the token format.
	localparam int WIN_AW    = 12;
	localparam int WIN_DEPTH = 1 << WIN_AW;
	localparam int BYTE_W    = 8;

	// Token format constants.
	localparam logic [4:0] MIN_MATCH  = 5'd3;
	localparam logic [3:0] FLAG_COUNT = 4'd8;

	// Configuration register indexes.
	localparam logic CFG_RESULT_SIZE = 1'b0;
	localparam logic CFG_EXPAND_MODE = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_write;     // write zero at the clearing address and advance
		logic take;          // latch an accepted item, applying its begin flag
		logic set_finished;  // mark the current result complete
		logic emit_err;      // emit the data error result
		logic emit_byte;     // emit the held byte unchanged (stored mode)
		logic literal;       // write the held byte to the window and emit it
		logic flag_load;     // load a new flag byte
		logic hold_low;      // keep the first byte of a match
		logic match_start;   // decode distance and length from the second byte
		logic match_read;    // read one byte of the match from the window
		logic match_write;   // copy the read byte to the window and emit it
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;      // clearing address is at the last entry
		logic finished;
		logic size_reached;  // produced count at or above the result size
		logic empty;
		logic stored;        // stored pass-through mode
		logic token_phase;
		logic flag_needed;
		logic flag_bit;
		logic match_left;
		logic out_free;      // output register can take a byte this cycle
	} dp_status_t;

endpackage

### sv/lzse_ram.sv
// Generic single write port, single read port RAM with registered read data.
module lzse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### sv/lzse_dp.sv
// Datapath of the LZSS stream expander: parsing state, window, counters and output register.
module lzse_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lzse_pkg::ctrl_cmd_t  cmd,
	output lzse_pkg::dp_status_t status,
	input  logic [7:0]           data_byte,
	input  logic                 begin_result,
	input  logic                 source_empty,
	input  logic                 cfg_valid,
	input  logic                 cfg_index,
	input  logic [31:0]          cfg_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_data,
	output logic                 out_last,
	output logic                 data_error
);
	import lzse_pkg::*;

	logic [31:0]       result_size_q;
	logic              expand_mode_q;
	logic [7:0]        data_q;
	logic              empty_q;
	logic [WIN_AW-1:0] write_pos_q;
	logic [WIN_AW-1:0] clr_addr_q;
	logic [31:0]       produced_q;
	logic [7:0]        flag_bits_q;
	logic [3:0]        flag_index_q;
	logic              token_phase_q;
	logic [7:0]        held_low_q;
	logic              finished_q;
	logic [WIN_AW-1:0] dist_q;
	logic [4:0]        len_q;
	logic              out_valid_q;
	logic [7:0]        out_data_q;
	logic              out_last_q;
	logic              out_err_q;

	logic              emit_any;
	logic              emit_ok;
	logic [31:0]       produced_next;
	logic              last_next;
	logic [7:0]        emit_data;
	logic              win_wr_en;
	logic [WIN_AW-1:0] win_wr_addr;
	logic [7:0]        win_wr_data;
	logic [WIN_AW-1:0] win_rd_addr;
	logic [7:0]        win_rd_data;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_size_q <= '0;
			expand_mode_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RESULT_SIZE: result_size_q <= cfg_data;
				CFG_EXPAND_MODE: expand_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Emission of one output byte and the count it advances.
	assign emit_ok       = cmd.emit_byte | cmd.literal | cmd.match_write;
	assign emit_any      = emit_ok | cmd.emit_err;
	assign produced_next = produced_q + 32'd1;
	assign last_next     = (produced_next == result_size_q);
	assign emit_data     = cmd.match_write ? win_rd_data : data_q;

	// Window port selection: clearing sweep, literal bytes and match copies.
	assign win_wr_en   = cmd.clr_write | cmd.literal | cmd.match_write;
	assign win_wr_addr = cmd.clr_write ? clr_addr_q : write_pos_q;
	assign win_wr_data = cmd.clr_write ? 8'd0 : emit_data;
	assign win_rd_addr = write_pos_q - dist_q;

	lzse_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(WIN_DEPTH)
	) u_window (
		.clk    (clk),
		.wr_en  (win_wr_en),
		.wr_addr(win_wr_addr),
		.wr_data(win_wr_data),
		.rd_en  (cmd.match_read),
		.rd_addr(win_rd_addr),
		.rd_data(win_rd_data)
	);

	// Clearing sweep address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_write) begin
			clr_addr_q <= clr_addr_q + WIN_AW'(1);
		end
	end

	// Held item.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			data_q  <= data_byte;
			empty_q <= source_empty;
		end
	end

	// Parsing state and counters; a begin flag restarts them as the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q   <= '0;
			produced_q    <= '0;
			flag_bits_q   <= '0;
			flag_index_q  <= FLAG_COUNT;
			token_phase_q <= 1'b0;
			held_low_q    <= '0;
			finished_q    <= 1'b0;
			dist_q        <= '0;
			len_q         <= '0;
		end else begin
			if (cmd.take && begin_result) begin
				write_pos_q   <= '0;
				produced_q    <= '0;
				flag_bits_q   <= '0;
				flag_index_q  <= FLAG_COUNT;
				token_phase_q <= 1'b0;
				held_low_q    <= '0;
				finished_q    <= 1'b0;
			end
			if (cmd.set_finished || cmd.emit_err) begin
				finished_q <= 1'b1;
			end
			if (emit_ok) begin
				produced_q <= produced_next;
				if (last_next) begin
					finished_q <= 1'b1;
				end
			end
			if (cmd.literal || cmd.match_write) begin
				write_pos_q <= write_pos_q + WIN_AW'(1);
			end
			if (cmd.literal) begin
				flag_index_q <= flag_index_q + 4'd1;
			end
			if (cmd.flag_load) begin
				flag_bits_q  <= data_q;
				flag_index_q <= '0;
			end
			if (cmd.hold_low) begin
				held_low_q    <= data_q;
				token_phase_q <= 1'b1;
			end
			if (cmd.match_start) begin
				dist_q        <= {data_q[7:4], held_low_q} + WIN_AW'(1);
				len_q         <= {1'b0, data_q[3:0]} + MIN_MATCH;
				token_phase_q <= 1'b0;
				flag_index_q  <= flag_index_q + 4'd1;
			end
			if (cmd.match_write) begin
				len_q <= len_q - 5'd1;
			end
		end
	end

	// Output register: loads a byte when free, empties when the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_any) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_any) begin
			out_data_q <= cmd.emit_err ? 8'd0 : emit_data;
			out_last_q <= cmd.emit_err ? 1'b0 : last_next;
			out_err_q  <= cmd.emit_err;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign out_last   = out_last_q;
	assign data_error = out_err_q;

	// Status towards the controller.
	always_comb begin
		status              = '0;
		status.clr_done     = &clr_addr_q;
		status.finished     = finished_q;
		status.size_reached = (produced_q >= result_size_q);
		status.empty        = empty_q;
		status.stored       = !expand_mode_q;
		status.token_phase  = token_phase_q;
		status.flag_needed  = flag_index_q[3];
		status.flag_bit     = flag_bits_q[flag_index_q[2:0]];
		status.match_left   = (len_q != 5'd0);
		status.out_free     = !out_valid_q || !out_stall;
	end

`ifndef SYNTHESIS
	// A byte is only loaded when the output register can take it.
	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit_any |-> (!out_valid_q || !out_stall))
		else $error("output byte loaded over a stalled output transaction");

	// The flag index never passes the flag byte's eight tokens.
	a_flag_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		flag_index_q[3] |-> (flag_index_q[2:0] == 3'd0))
		else $error("flag index beyond eight");

	// A half-read match token only exists inside a flag group.
	a_token_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		token_phase_q |-> !flag_index_q[3])
		else $error("match token pending with no flag byte");

	// Window reads are never issued back-to-back in a match copy.
	a_copy_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.match_read |=> !cmd.match_read)
		else $error("back-to-back window reads in a match copy");
`endif

endmodule

### sv/lzse_ctrl.sv
// Controller state machine of the LZSS stream expander.
module lzse_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lzse_pkg::dp_status_t status,
	output lzse_pkg::ctrl_cmd_t  cmd
);
	import lzse_pkg::*;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_MREAD  = 3'd3;
	localparam logic [2:0] ST_MWRITE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_write = 1'b1;
				if (status.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (status.finished) begin
					state_d = ST_IDLE;
				end else if (status.size_reached) begin
					cmd.set_finished = 1'b1;
					state_d          = ST_IDLE;
				end else if (status.empty) begin
					if (status.out_free) begin
						cmd.emit_err = 1'b1;
						state_d      = ST_IDLE;
					end
				end else if (status.stored) begin
					if (status.out_free) begin
						cmd.emit_byte = 1'b1;
						state_d       = ST_IDLE;
					end
				end else if (status.token_phase) begin
					cmd.match_start = 1'b1;
					state_d         = ST_MREAD;
				end else if (status.flag_needed) begin
					cmd.flag_load = 1'b1;
					state_d       = ST_IDLE;
				end else if (status.flag_bit) begin
					if (status.out_free) begin
						cmd.literal = 1'b1;
						state_d     = ST_IDLE;
					end
				end else begin
					cmd.hold_low = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_MREAD: begin
				if (!status.match_left || status.size_reached) begin
					state_d = ST_IDLE;
				end else begin
					cmd.match_read = 1'b1;
					state_d        = ST_MWRITE;
				end
			end
			ST_MWRITE: begin
				if (status.out_free) begin
					cmd.match_write = 1'b1;
					state_d         = ST_MREAD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Items are taken only while waiting for the next one.
	assign in_stall = (state_q != ST_IDLE);

endmodule

### sv/lzss_stream_expander_top.sv
// Top level of the LZSS stream expander.
// An item is taken in the idle state and decided in the decide state; a byte emitted there
// is loaded into the output register. Flag items pass only through those two states;
// literal and stored items also wait there while the output is stalled. A match alternates
// read and write states, as a registered window read precedes every copied byte.
// Reset clears the state at once, then a pass zeroes all 4096 window entries with input stalled.
module lzss_stream_expander_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        begin_result,
	input  logic        source_empty,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_data,
	output logic        out_last,
	output logic        data_error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import lzse_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Configuration transactions are always taken.
	assign cfg_ready = 1'b1;

	lzse_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	lzse_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.data_byte   (data_byte),
		.begin_result(begin_result),
		.source_empty(source_empty),
		.cfg_valid   (cfg_valid & cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.out_last    (out_last),
		.data_error  (data_error)
	);

endmodule
